// ===== src/cse_pkg.sv =====
package cse_pkg;

    localparam int MAX_KNOTS = 64;
    localparam int ADDR_W    = $clog2(MAX_KNOTS);
    localparam int KC_W      = 7;
    localparam int KC_MIN    = 2;
    localparam int PADDR_W   = 3;
    localparam int ACC_W     = 63;
    localparam int MAG_W     = ACC_W - 1;
    localparam int D_W       = 33;

    typedef logic signed [31:0]      t_knot;
    typedef logic signed [47:0]      t_coef;
    typedef logic signed [31:0]      t_val;
    typedef logic [5:0]              t_seg;
    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic signed [D_W-1:0]   t_diff;

    localparam t_acc ACC_LIM = t_acc'({MAG_W{1'b1}});

    localparam logic [0:0] CMD_LOAD  = 1'b0;
    localparam logic [0:0] CMD_QUERY = 1'b1;

    localparam logic [0:0] REG_KNOT_COUNT = 1'b0;
    localparam logic [KC_W-1:0] KC_RESET = KC_W'(2);

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_LOAD = 2'd1,
        ST_NEG  = 2'd2,
        ST_SAT  = 2'd3
    } t_status;

    typedef struct packed {
        t_coef c0;
        t_coef c1;
        t_coef c2;
        t_coef c3;
    } t_coef_set;

    typedef struct packed {
        logic  start;
        t_acc  a;
        t_diff d;
    } t_mul_req;

    typedef struct packed {
        logic done;
        t_acc prod;
        logic sat;
    } t_mul_rsp;

endpackage

// ===== src/cse_if.sv =====
interface cse_in_if;
    import cse_pkg::*;

    logic       valid;
    logic       ready;
    logic [0:0] command;
    t_seg       entry_index;
    t_knot      knot_value;
    t_coef      coef_cubic;
    t_coef      coef_square;
    t_coef      coef_linear;
    t_coef      coef_constant;
    t_knot      query_strike;

    modport source (
        output valid, command, entry_index, knot_value, coef_cubic, coef_square,
               coef_linear, coef_constant, query_strike,
        input  ready
    );

    modport sink (
        input  valid, command, entry_index, knot_value, coef_cubic, coef_square,
               coef_linear, coef_constant, query_strike,
        output ready
    );
endinterface

interface cse_out_if;
    import cse_pkg::*;

    logic       valid;
    logic       ready;
    t_val       value;
    t_seg       segment_used;
    logic [1:0] status;

    modport source (
        output valid, value, segment_used, status,
        input  ready
    );

    modport sink (
        input  valid, value, segment_used, status,
        output ready
    );
endinterface

// ===== src/cse_mul.sv =====
module cse_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cse_pkg::t_mul_req i_req,
    output cse_pkg::t_mul_rsp o_rsp
);
    import cse_pkg::*;

    typedef enum logic [2:0] {
        MP_IDLE,
        MP_LO,
        MP_HI,
        MP_SUM,
        MP_SIGN
    } t_mph;

    t_mph             r_ph;
    logic [MAG_W-1:0] r_ua;
    logic [31:0]      r_ud;
    logic             r_neg;
    logic [63:0]      r_plo;
    logic [63:0]      r_phi;
    logic [MAG_W-1:0] r_mag;
    logic             r_big;
    t_acc             r_prod;
    logic             r_done;

    logic [ACC_W-1:0] a_abs;
    logic [D_W-1:0]   d_abs;
    logic [31:0]      mul_a;
    logic [63:0]      mul_p;
    logic [63:0]      rnd;
    logic [ACC_W-1:0] sum;

    assign a_abs = i_req.a[ACC_W-1] ? (~i_req.a + 1'b1) : i_req.a;
    assign d_abs = i_req.d[D_W-1] ? (~i_req.d + 1'b1) : i_req.d;
    assign mul_a = (r_ph == MP_LO) ? r_ua[31:0] : 32'(r_ua[MAG_W-1:32]);
    assign mul_p = {32'b0, mul_a} * {32'b0, r_ud};
    assign rnd   = r_plo + 64'h8000;
    assign sum   = {1'b0, r_phi[45:0], 16'b0} + {15'b0, rnd[63:16]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= MP_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_ph)
                MP_IDLE: begin
                    if (i_req.start) begin
                        r_ua  <= a_abs[MAG_W-1:0];
                        r_ud  <= d_abs[31:0];
                        r_neg <= i_req.a[ACC_W-1] != i_req.d[D_W-1];
                        r_ph  <= MP_LO;
                    end
                end
                MP_LO: begin
                    r_plo <= mul_p;
                    r_ph  <= MP_HI;
                end
                MP_HI: begin
                    r_phi <= mul_p;
                    r_ph  <= MP_SUM;
                end
                MP_SUM: begin
                    if ((r_phi[63:46] != '0) || sum[ACC_W-1]) begin
                        r_mag <= {MAG_W{1'b1}};
                        r_big <= 1'b1;
                    end else begin
                        r_mag <= sum[MAG_W-1:0];
                        r_big <= 1'b0;
                    end
                    r_ph <= MP_SIGN;
                end
                MP_SIGN: begin
                    r_prod <= r_neg ? -t_acc'({1'b0, r_mag}) : t_acc'({1'b0, r_mag});
                    r_done <= 1'b1;
                    r_ph   <= MP_IDLE;
                end
                default: r_ph <= MP_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_prod;
    assign o_rsp.sat  = r_big;

endmodule

// ===== src/cse_ctrl.sv =====
module cse_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [cse_pkg::KC_W-1:0] i_knot_count,
    cse_in_if.sink                   i_in,
    cse_out_if.source                o_out,
    output cse_pkg::t_mul_req        o_mul_req,
    input  cse_pkg::t_mul_rsp        i_mul_rsp
);
    import cse_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_FIRST,
        S_RD_LAST,
        S_CLASS,
        S_SRCH,
        S_SEG_RD,
        S_SEG_D,
        S_MSTART,
        S_MWAIT,
        S_ADD,
        S_RND,
        S_SATR,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        MD_MID,
        MD_HIGH,
        MD_LOW
    } t_mode;

    typedef enum logic [3:0] {
        OP_H1,
        OP_H2,
        OP_H3,
        OP_P1,
        OP_P2,
        OP_Q,
        OP_S1,
        OP_S2,
        OP_S3,
        OP_S4,
        OP_S5,
        OP_XH,
        OP_XL,
        OP_FIN
    } t_op;

    t_knot     knot_mem [MAX_KNOTS];
    t_coef_set coef_mem [MAX_KNOTS];

    t_state      r_state;
    t_mode       r_mode;
    t_op         r_op;
    t_knot       r_kd;
    t_coef_set   r_cd;
    t_knot       r_strike;
    t_knot       r_first;
    t_knot       r_x;
    t_coef       r_c0lin;
    t_coef_set   r_coef;
    t_diff       r_d;
    t_diff       r_xd;
    t_acc        r_acc;
    t_acc        r_t;
    t_acc        r_q;
    t_acc        r_s;
    t_acc        r_prod;
    logic        r_sat;
    logic [ADDR_W-1:0] r_i;
    logic [ADDR_W-1:0] r_seg;
    logic [46:0] r_rm;
    logic        r_neg;
    t_val        r_res_val;
    t_seg        r_res_seg;
    t_status     r_res_status;
    logic        r_out_valid;
    t_val        r_out_val;
    t_seg        r_out_seg;
    t_status     r_out_status;

    logic [KC_W-1:0]   n_use;
    logic [ADDR_W-1:0] nm1;
    logic [ADDR_W-1:0] nm2;
    logic [ADDR_W-1:0] rd_addr;
    logic              accept;
    logic              mem_we;
    t_op               op_next;
    t_acc              add_a;
    t_acc              add_b;
    t_acc              add_y;
    logic              add_sat;
    logic [63:0]       sum64;
    logic [ACC_W-1:0]  acc_abs;
    logic [ACC_W-1:0]  acc_rnd;
    logic              rm_over;
    t_knot             x_low;

    always_comb begin
        if (i_knot_count < KC_W'(KC_MIN)) begin
            n_use = KC_W'(KC_MIN);
        end else if (i_knot_count > KC_W'(MAX_KNOTS)) begin
            n_use = KC_W'(MAX_KNOTS);
        end else begin
            n_use = i_knot_count;
        end
    end

    assign nm1    = ADDR_W'(n_use - KC_W'(1));
    assign nm2    = ADDR_W'(n_use - KC_W'(2));
    assign accept = i_in.valid && i_in.ready;
    assign mem_we = accept && (i_in.command == CMD_LOAD)
                    && (int'(i_in.entry_index) < MAX_KNOTS);
    assign x_low  = (r_strike < r_first) ? r_first : r_strike;

    always_comb begin
        unique case (r_state)
            S_RD_LAST: rd_addr = nm1;
            S_CLASS:   rd_addr = ADDR_W'(1);
            S_SRCH:    rd_addr = ADDR_W'(r_i + 1'b1);
            S_SEG_RD:  rd_addr = r_seg;
            default:   rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            knot_mem[i_in.entry_index] <= i_in.knot_value;
            coef_mem[i_in.entry_index] <= {i_in.coef_cubic, i_in.coef_square,
                                           i_in.coef_linear, i_in.coef_constant};
        end
        r_kd <= knot_mem[rd_addr];
        r_cd <= coef_mem[rd_addr];
    end

    always_comb begin
        o_mul_req.start = (r_state == S_MSTART);
        o_mul_req.a     = r_acc;
        o_mul_req.d     = r_d;
        add_a           = r_prod;
        add_b           = '0;
        op_next         = OP_FIN;
        unique case (r_op)
            OP_H1: begin
                add_b   = t_acc'(r_coef.c1);
                op_next = OP_H2;
            end
            OP_H2: begin
                add_b   = t_acc'(r_coef.c2);
                op_next = OP_H3;
            end
            OP_H3: begin
                add_b = t_acc'(r_coef.c3);
                unique case (r_mode)
                    MD_HIGH: op_next = OP_P1;
                    MD_LOW:  op_next = OP_XL;
                    default: op_next = OP_FIN;
                endcase
            end
            OP_P1: begin
                o_mul_req.a = t_acc'(r_coef.c0);
                op_next     = OP_P2;
            end
            OP_P2: begin
                o_mul_req.a = r_t;
                op_next     = OP_Q;
            end
            OP_Q: begin
                o_mul_req.a = t_acc'(r_coef.c1);
                op_next     = OP_S1;
            end
            OP_S1: begin
                add_a   = r_t;
                add_b   = r_t;
                op_next = OP_S2;
            end
            OP_S2: begin
                add_a   = r_s;
                add_b   = r_t;
                op_next = OP_S3;
            end
            OP_S3: begin
                add_a   = r_q;
                add_b   = r_q;
                op_next = OP_S4;
            end
            OP_S4: begin
                add_a   = r_s;
                add_b   = r_q;
                op_next = OP_S5;
            end
            OP_S5: begin
                add_a   = r_s;
                add_b   = t_acc'(r_coef.c2);
                op_next = OP_XH;
            end
            OP_XH: begin
                o_mul_req.a = r_s;
                o_mul_req.d = r_xd;
                add_a       = r_acc;
                add_b       = r_prod;
            end
            OP_XL: begin
                o_mul_req.a = t_acc'(r_c0lin);
                o_mul_req.d = r_xd;
                add_a       = r_acc;
                add_b       = r_prod;
            end
            default: op_next = OP_FIN;
        endcase
    end

    always_comb begin
        sum64   = 64'(add_a) + 64'(add_b);
        add_sat = 1'b0;
        add_y   = t_acc'(sum64);
        if ($signed(sum64) > 64'(ACC_LIM)) begin
            add_sat = 1'b1;
            add_y   = ACC_LIM;
        end else if ($signed(sum64) < -64'(ACC_LIM)) begin
            add_sat = 1'b1;
            add_y   = -ACC_LIM;
        end
    end

    assign acc_abs = r_acc[ACC_W-1] ? (~r_acc + 1'b1) : r_acc;
    assign acc_rnd = acc_abs + ACC_W'(16'h8000);
    assign rm_over = r_neg ? (r_rm > 47'h80000000) : (r_rm > 47'h7FFFFFFF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_res_val <= '0;
                        r_res_seg <= '0;
                        r_sat     <= 1'b0;
                        r_strike  <= i_in.query_strike;
                        if (i_in.command == CMD_LOAD) begin
                            r_res_status <= ST_LOAD;
                            r_state      <= S_DONE;
                        end else if (i_in.query_strike[31]) begin
                            r_res_status <= ST_NEG;
                            r_state      <= S_DONE;
                        end else begin
                            r_state <= S_RD_FIRST;
                        end
                    end
                end
                S_RD_FIRST: r_state <= S_RD_LAST;
                S_RD_LAST: begin
                    r_first <= r_kd;
                    r_c0lin <= r_cd.c2;
                    r_state <= S_CLASS;
                end
                S_CLASS: begin
                    if (r_strike > r_kd) begin
                        r_mode  <= MD_HIGH;
                        r_x     <= r_kd;
                        r_xd    <= t_diff'(r_strike) - t_diff'(r_kd);
                        r_seg   <= nm2;
                        r_state <= S_SEG_RD;
                    end else begin
                        r_mode <= (r_strike < r_first) ? MD_LOW : MD_MID;
                        r_x    <= x_low;
                        r_xd   <= t_diff'(r_strike) - t_diff'(r_first);
                        r_i    <= ADDR_W'(1);
                        if (x_low == r_kd) begin
                            r_seg   <= nm2;
                            r_state <= S_SEG_RD;
                        end else begin
                            r_state <= S_SRCH;
                        end
                    end
                end
                S_SRCH: begin
                    if (r_kd > r_x) begin
                        r_seg   <= ADDR_W'(r_i - 1'b1);
                        r_state <= S_SEG_RD;
                    end else if (r_i == nm1) begin
                        r_seg   <= nm2;
                        r_state <= S_SEG_RD;
                    end else begin
                        r_i <= ADDR_W'(r_i + 1'b1);
                    end
                end
                S_SEG_RD: r_state <= S_SEG_D;
                S_SEG_D: begin
                    r_d     <= t_diff'(r_x) - t_diff'(r_kd);
                    r_coef  <= r_cd;
                    r_acc   <= t_acc'(r_cd.c0);
                    r_op    <= OP_H1;
                    r_state <= S_MSTART;
                end
                S_MSTART: r_state <= S_MWAIT;
                S_MWAIT: begin
                    if (i_mul_rsp.done) begin
                        r_prod  <= i_mul_rsp.prod;
                        r_sat   <= r_sat | i_mul_rsp.sat;
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_sat <= r_sat | add_sat;
                    unique case (r_op)
                        OP_P1, OP_P2:        r_t <= add_y;
                        OP_Q, OP_S3:         r_q <= add_y;
                        OP_S1, OP_S2, OP_S4,
                        OP_S5:               r_s <= add_y;
                        default:             r_acc <= add_y;
                    endcase
                    r_op <= op_next;
                    unique case (op_next)
                        OP_S1, OP_S2, OP_S3, OP_S4, OP_S5: r_state <= S_ADD;
                        OP_FIN:                            r_state <= S_RND;
                        default:                           r_state <= S_MSTART;
                    endcase
                end
                S_RND: begin
                    r_rm    <= acc_rnd[ACC_W-1:16];
                    r_neg   <= r_acc[ACC_W-1];
                    r_state <= S_SATR;
                end
                S_SATR: begin
                    r_res_seg    <= t_seg'(r_seg);
                    r_res_status <= (r_sat || rm_over) ? ST_SAT : ST_OK;
                    if (r_neg) begin
                        if (rm_over) begin
                            r_res_val <= t_val'(32'h80000000);
                        end else begin
                            r_res_val <= -t_val'(r_rm[31:0]);
                        end
                    end else begin
                        if (rm_over) begin
                            r_res_val <= t_val'(32'h7FFFFFFF);
                        end else begin
                            r_res_val <= t_val'(r_rm[31:0]);
                        end
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_val    <= r_res_val;
                        r_out_seg    <= r_res_seg;
                        r_out_status <= r_res_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.value        = r_out_val;
    assign o_out.segment_used = r_out_seg;
    assign o_out.status       = r_out_status;

`ifndef SYNTHESIS
    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mul_rsp.done |-> r_state == S_MWAIT)
        else $error("Multiplier result arrived while no product was awaited.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_in.ready)
        else $error("Block took a second transaction right after the first.");

    a_search_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SRCH |-> (r_i <= nm1) && (r_i != '0))
        else $error("Knot search index left the active table.");

    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.status == ST_LOAD)
        |-> (o_out.value == '0) && (o_out.segment_used == '0))
        else $error("Load transaction produced a nonzero result.");
`endif

endmodule

// ===== src/cubic_spline_evaluator.sv =====
// Piecewise cubic spline evaluator with linear extrapolation. A load transaction writes one
// knot and its four segment coefficients; a query transaction returns the Q16.16 value at the
// strike, the segment used and a status. Loads and negative strikes skip the evaluation. Unless
// the strike is at or above the last knot, a query first scans the knot memory linearly, one knot
// per cycle through its single read port; it then evaluates in Horner form on one shared 32x32
// multiplier, which forms each product from a low and a high partial product before the add.
// The block accepts no new transaction until the current one is finished, but a finished
// result waits in the output register while the next one is taken.
module cubic_spline_evaluator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cse_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    cse_in_if.sink                      i_in,
    cse_out_if.source                   o_out
);
    import cse_pkg::*;

    logic [KC_W-1:0] r_knot_count;
    t_mul_req        mul_req;
    t_mul_rsp        mul_rsp;
    logic            cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready
                    && (paddr[PADDR_W-1:2] == REG_KNOT_COUNT);
    assign prdata = (paddr[PADDR_W-1:2] == REG_KNOT_COUNT) ? 32'(r_knot_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knot_count <= KC_RESET;
        end else if (cfg_we) begin
            r_knot_count <= pwdata[KC_W-1:0];
        end
    end

    cse_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_knot_count (r_knot_count),
        .i_in         (i_in),
        .o_out        (o_out),
        .o_mul_req    (mul_req),
        .i_mul_rsp    (mul_rsp)
    );

    cse_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

endmodule
